FILE: src/ipfl4_pkg.sv
// Package: shared constants, types and hash helper for the fragment L4 table.
package ipfl4_pkg;

   localparam int DefaultSets = 256;
   localparam int DefaultWays = 4;
   localparam int KeyBytes = 36;
   localparam int EntryWidth = 1 + 64 * 4 + 33 + 40;

   typedef enum logic [2:0] {
      ST_RECORDED    = 3'd0,
      ST_PRESENT     = 3'd1,
      ST_MATCHED     = 3'd2,
      ST_UNMATCHED   = 3'd3,
      ST_FULL        = 3'd4,
      ST_UNSUPPORTED = 3'd5
   } status_type;

   typedef struct packed {
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [32:0] tag;
   } key_type;

   typedef struct packed {
      logic        supported;
      key_type     key;
      logic        first;
      logic        more;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
   } job_type;

   function automatic logic [31:0] sdbm_byte(input logic [31:0] h, input logic [7:0] b);
      sdbm_byte = {24'd0, b} + (h << 6) + (h << 16) - h;
   endfunction

endpackage

FILE: src/ipfl4_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module ipfl4_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/ipfl4_front.sv
// Front end: capture descriptor, hash key bytes one per cycle, hand job to back.
module ipfl4_front #(
   parameter int TableSets = ipfl4_pkg::DefaultSets
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [3:0]                   req_ip_version,
   input  logic [63:0]                  req_src_addr_hi,
   input  logic [63:0]                  req_src_addr_lo,
   input  logic [63:0]                  req_dst_addr_hi,
   input  logic [63:0]                  req_dst_addr_lo,
   input  logic [31:0]                  req_frag_id,
   input  logic [12:0]                  req_frag_offset,
   input  logic                         req_more_fragments,
   input  logic [15:0]                  req_src_port,
   input  logic [15:0]                  req_dst_port,
   input  logic [7:0]                   req_protocol,
   output logic                         job_valid,
   output ipfl4_pkg::job_type           job,
   output logic [$clog2(TableSets)-1:0] job_set,
   input  logic                         job_take
);
   import ipfl4_pkg::*;

   localparam int SetBits = $clog2(TableSets);
   localparam logic [63:0] RecipMul =
      ((64'd1 << (32 + SetBits)) + 64'(TableSets) - 64'd1) / 64'(TableSets);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_HASH = 4'b0010,
      F_DIV  = 4'b0100,
      F_DONE = 4'b1000
   } fstate_type;

   fstate_type            state_ff, state_in;
   job_type               job_ff, job_in;
   logic [8*KeyBytes-1:0] bytes_ff, bytes_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [5:0]            nbytes_ff, nbytes_in;
   logic [31:0]           h_ff, h_in;
   logic [31:0]           q_ff, q_in;
   logic [64:0]           prod;
   logic [31:0]           rem;
   logic                  v4, v6;
   logic [8*KeyBytes-1:0] seq;

   assign v4 = req_ip_version == 4'd4;
   assign v6 = req_ip_version == 4'd6;

   assign prod = 65'(h_ff) * 65'(RecipMul[32:0]);
   assign rem  = h_ff - q_ff * 32'(TableSets);

   always_comb begin
      seq = '0;
      for (int k = 0; k < 4; k++) begin
         seq[8*(2*k)   +: 8] = req_src_addr_hi[16*(3-k)    +: 8];
         seq[8*(2*k+1) +: 8] = req_src_addr_hi[16*(3-k)+8  +: 8];
         seq[8*(2*k+8) +: 8] = req_src_addr_lo[16*(3-k)    +: 8];
         seq[8*(2*k+9) +: 8] = req_src_addr_lo[16*(3-k)+8  +: 8];
         seq[8*(2*k+16) +: 8] = req_dst_addr_hi[16*(3-k)   +: 8];
         seq[8*(2*k+17) +: 8] = req_dst_addr_hi[16*(3-k)+8 +: 8];
         seq[8*(2*k+24) +: 8] = req_dst_addr_lo[16*(3-k)   +: 8];
         seq[8*(2*k+25) +: 8] = req_dst_addr_lo[16*(3-k)+8 +: 8];
      end
      seq[8*32 +: 32] = req_frag_id;
      if (v4) begin
         seq = '0;
         seq[31:0]  = req_src_addr_lo[31:0];
         seq[63:32] = req_dst_addr_lo[31:0];
         seq[79:64] = req_frag_id[15:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      bytes_in  = bytes_ff;
      cnt_in    = cnt_ff;
      nbytes_in = nbytes_ff;
      h_in      = h_ff;
      q_in      = q_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               job_in.supported = v4 || v6;
               job_in.key.src_hi = v4 ? 64'd0 : req_src_addr_hi;
               job_in.key.dst_hi = v4 ? 64'd0 : req_dst_addr_hi;
               job_in.key.src_lo = v4 ? {32'd0, req_src_addr_lo[31:0]} : req_src_addr_lo;
               job_in.key.dst_lo = v4 ? {32'd0, req_dst_addr_lo[31:0]} : req_dst_addr_lo;
               job_in.key.tag = v4 ? {17'd0, req_frag_id[15:0]} : {1'b1, req_frag_id};
               job_in.first    = req_frag_offset == 13'd0;
               job_in.more     = req_more_fragments;
               job_in.src_port = req_src_port;
               job_in.dst_port = req_dst_port;
               job_in.protocol = req_protocol;
               bytes_in  = seq;
               nbytes_in = v4 ? 6'd12 : 6'(KeyBytes);
               cnt_in    = '0;
               h_in      = '0;
               state_in  = (v4 || v6) ? F_HASH : F_DONE;
            end
         end
         F_HASH: begin
            h_in     = sdbm_byte(h_ff, bytes_ff[7:0]);
            bytes_in = bytes_ff >> 8;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == nbytes_ff - 6'd1) begin
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            q_in     = 32'(prod >> (32 + SetBits));
            state_in = F_DONE;
         end
         F_DONE: begin
            if (job_take) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff    <= job_in;
      bytes_ff  <= bytes_in;
      cnt_ff    <= cnt_in;
      nbytes_ff <= nbytes_in;
      h_ff      <= h_in;
      q_ff      <= q_in;
   end

   assign busy      = state_ff != F_IDLE;
   assign job_valid = state_ff == F_DONE;
   assign job       = job_ff;
   assign job_set   = rem[SetBits-1:0];
endmodule

FILE: src/ipfl4_back.sv
// Back end: clear table, read set ways, compare, update and emit result word.
module ipfl4_back #(
   parameter int TableSets = ipfl4_pkg::DefaultSets,
   parameter int TableWays = ipfl4_pkg::DefaultWays
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  ipfl4_pkg::job_type           job,
   input  logic [$clog2(TableSets)-1:0] job_set,
   output logic                         job_take,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic [15:0]                  rsp_out_src_port,
   output logic [15:0]                  rsp_out_dst_port,
   output logic [7:0]                   rsp_out_protocol,
   output logic                         rsp_entry_released
);
   import ipfl4_pkg::*;

   localparam int SetBits = $clog2(TableSets);
   localparam int WayBits = (TableWays > 1) ? $clog2(TableWays) : 1;
   localparam int Depth   = TableSets * TableWays;
   localparam int AddrBits = $clog2(Depth);

   typedef enum logic [4:0] {
      B_CLEAR = 5'b00001,
      B_IDLE  = 5'b00010,
      B_READ  = 5'b00100,
      B_CHECK = 5'b01000,
      B_WRITE = 5'b10000
   } bstate_type;

   typedef struct packed {
      logic        valid;
      key_type     key;
      logic [39:0] pp;
   } entry_type;

   bstate_type             state_ff, state_in;
   logic [AddrBits:0]      clr_ff, clr_in;
   logic [WayBits:0]       way_ff, way_in;
   logic [SetBits-1:0]     set_ff, set_in;
   job_type                job_ff, job_in;
   logic                   hit_ff, hit_in;
   logic                   free_ff, free_in;
   logic [WayBits-1:0]     hitw_ff, hitw_in, freew_ff, freew_in;
   logic [39:0]            pp_ff, pp_in;
   logic                   we;
   logic [AddrBits-1:0]    waddr, raddr;
   entry_type              wdata, rdata;
   logic [AddrBits-1:0]    rd_way_addr;
   logic                   rv_ff, rv_in;
   logic [2:0]             st_ff, st_in;
   logic [15:0]            sp_ff, sp_in, dp_ff, dp_in;
   logic [7:0]             pr_ff, pr_in;
   logic                   rel_ff, rel_in;

   assign rd_way_addr = AddrBits'(set_ff * TableWays) + AddrBits'(way_ff[WayBits-1:0]);

   ipfl4_ram #(.Width(EntryWidth), .Depth(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      way_in   = way_ff;
      set_in   = set_ff;
      job_in   = job_ff;
      hit_in   = hit_ff;
      free_in  = free_ff;
      hitw_in  = hitw_ff;
      freew_in = freew_ff;
      pp_in    = pp_ff;
      we       = 1'b0;
      waddr    = clr_ff[AddrBits-1:0];
      wdata    = '0;
      raddr    = rd_way_addr;
      job_take = 1'b0;
      rv_in    = 1'b0;
      st_in    = st_ff;
      sp_in    = sp_ff;
      dp_in    = dp_ff;
      pr_in    = pr_ff;
      rel_in   = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            we     = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AddrBits+1)'(Depth - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               job_in   = job;
               set_in   = job_set;
               way_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               if (!job.supported) begin
                  rv_in = 1'b1;
                  st_in = ST_UNSUPPORTED;
                  sp_in = job.src_port;
                  dp_in = job.dst_port;
                  pr_in = job.protocol;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            state_in = B_CHECK;
         end
         B_CHECK: begin
            if (rdata.valid) begin
               if (!hit_ff && rdata.key == job_ff.key) begin
                  hit_in  = 1'b1;
                  hitw_in = way_ff[WayBits-1:0];
                  pp_in   = rdata.pp;
               end
            end else if (!free_ff) begin
               free_in  = 1'b1;
               freew_in = way_ff[WayBits-1:0];
            end
            way_in = way_ff + 1'b1;
            if (way_ff == (WayBits+1)'(TableWays - 1)) begin
               state_in = B_WRITE;
            end else begin
               raddr    = rd_way_addr + AddrBits'(1);
               state_in = B_CHECK;
            end
            if (way_ff != (WayBits+1)'(TableWays - 1)) begin
               state_in = B_READ;
            end
         end
         B_WRITE: begin
            state_in = B_IDLE;
            rv_in    = 1'b1;
            sp_in    = job_ff.src_port;
            dp_in    = job_ff.dst_port;
            pr_in    = job_ff.protocol;
            wdata.key = job_ff.key;
            wdata.pp  = {job_ff.src_port, job_ff.dst_port, job_ff.protocol};
            if (job_ff.first) begin
               if (hit_ff) begin
                  st_in = ST_PRESENT;
               end else if (!free_ff) begin
                  st_in = ST_FULL;
               end else begin
                  st_in       = ST_RECORDED;
                  we          = 1'b1;
                  waddr       = AddrBits'(set_ff * TableWays) + AddrBits'(freew_ff);
                  wdata.valid = 1'b1;
               end
            end else if (hit_ff) begin
               st_in = ST_MATCHED;
               sp_in = pp_ff[39:24];
               dp_in = pp_ff[23:8];
               pr_in = pp_ff[7:0];
               if (!job_ff.more) begin
                  rel_in      = 1'b1;
                  we          = 1'b1;
                  waddr       = AddrBits'(set_ff * TableWays) + AddrBits'(hitw_ff);
                  wdata.valid = 1'b0;
               end
            end else begin
               st_in = ST_UNMATCHED;
            end
         end
         default: state_in = B_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      way_ff   <= way_in;
      set_ff   <= set_in;
      job_ff   <= job_in;
      hit_ff   <= hit_in;
      free_ff  <= free_in;
      hitw_ff  <= hitw_in;
      freew_ff <= freew_in;
      pp_ff    <= pp_in;
      st_ff    <= st_in;
      sp_ff    <= sp_in;
      dp_ff    <= dp_in;
      pr_ff    <= pr_in;
      rel_ff   <= rel_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = st_ff;
   assign rsp_out_src_port   = sp_ff;
   assign rsp_out_dst_port   = dp_ff;
   assign rsp_out_protocol   = pr_ff;
   assign rsp_entry_released = rel_ff & rv_ff;

   a_rel_match: assert property (@(posedge clock) disable iff (reset)
      rsp_entry_released |-> rsp_status == ST_MATCHED)
      else $error("release without match");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |-> state_ff == B_IDLE)
      else $error("job taken while busy");
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CLEAR |=> !rsp_valid)
      else $error("response during clear");
endmodule

FILE: src/ip_fragment_l4_info_table_core.sv
// Top level: IP fragment layer-4 info table.
//  channel | ports                  | handshake
//  request | start, busy, req_*     | taken when start && !busy
//  result  | rsp_valid, rsp_*       | one-cycle strobe, no back-pressure
//  The front hashes one key byte a cycle (12 for IPv4, 36 for IPv6), reduces the hash to a
//  set in F_DIV and holds the word in F_DONE; busy holds until the back takes it.
//  The back reads each way of the set in turn, through B_READ and B_CHECK, then updates
//  the set in B_WRITE, from which the result strobe is registered; an unsupported
//  version skips the hash and the way reads, and the back answers it from B_IDLE.
//  After reset the back clears one entry a cycle, all TABLE_SETS*TABLE_WAYS of them, before
//  the first lookup; the front may already take and hold one item meanwhile.
module ip_fragment_l4_info_table_core #(
   parameter int TABLE_SETS = ipfl4_pkg::DefaultSets,
   parameter int TABLE_WAYS = ipfl4_pkg::DefaultWays
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_ip_version,
   input  logic [63:0] req_src_addr_hi,
   input  logic [63:0] req_src_addr_lo,
   input  logic [63:0] req_dst_addr_hi,
   input  logic [63:0] req_dst_addr_lo,
   input  logic [31:0] req_frag_id,
   input  logic [12:0] req_frag_offset,
   input  logic        req_more_fragments,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0]  req_protocol,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_src_port,
   output logic [15:0] rsp_out_dst_port,
   output logic [7:0]  rsp_out_protocol,
   output logic        rsp_entry_released
);
   import ipfl4_pkg::*;

   logic                          job_valid, job_take;
   job_type                       job;
   logic [$clog2(TABLE_SETS)-1:0] job_set;

   ipfl4_front #(.TableSets(TABLE_SETS)) u_front (
      .clock, .reset, .start, .busy,
      .req_ip_version, .req_src_addr_hi, .req_src_addr_lo,
      .req_dst_addr_hi, .req_dst_addr_lo, .req_frag_id, .req_frag_offset,
      .req_more_fragments, .req_src_port, .req_dst_port, .req_protocol,
      .job_valid, .job, .job_set, .job_take
   );

   ipfl4_back #(.TableSets(TABLE_SETS), .TableWays(TABLE_WAYS)) u_back (
      .clock, .reset, .job_valid, .job, .job_set, .job_take,
      .rsp_valid, .rsp_status, .rsp_out_src_port, .rsp_out_dst_port,
      .rsp_out_protocol, .rsp_entry_released
   );
endmodule

FILE: bench/ipfl4_checker.sv
// Checker: predicts fragment table results and compares them with the block's output.
module ipfl4_checker
   import ipfl4_pkg::*;
#(
   parameter int TABLE_SETS = DefaultSets,
   parameter int TABLE_WAYS = DefaultWays
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [3:0]  req_ip_version,
   input  logic [63:0] req_src_addr_hi,
   input  logic [63:0] req_src_addr_lo,
   input  logic [63:0] req_dst_addr_hi,
   input  logic [63:0] req_dst_addr_lo,
   input  logic [31:0] req_frag_id,
   input  logic [12:0] req_frag_offset,
   input  logic        req_more_fragments,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0]  req_protocol,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_out_src_port,
   input  logic [15:0] rsp_out_dst_port,
   input  logic [7:0]  rsp_out_protocol,
   input  logic        rsp_entry_released,
   output int          failures,
   output int          pending,
   output int          words_seen,
   output int          matched_seen,
   output int          full_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Entries = TABLE_SETS * TABLE_WAYS;

   typedef struct packed {
      status_type  status;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
      logic        released;
   } outcome_type;

   logic        slot_valid [Entries];
   key_type     slot_key [Entries];
   logic [39:0] slot_l4 [Entries];
   outcome_type outcome_q[$];

   function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] b);
      return {24'd0, b} + (h << 6) + (h << 16) - h;
   endfunction

   function automatic logic [31:0] mix32(input logic [31:0] h, input logic [31:0] v);
      for (int i = 0; i < 4; i++) h = mix(h, v[8*i +: 8]);
      return h;
   endfunction

   function automatic logic [31:0] mix128(input logic [31:0] h, input logic [127:0] v);
      logic [15:0] w;
      for (int k = 7; k >= 0; k--) begin
         w = v[16*k +: 16];
         h = mix(h, w[7:0]);
         h = mix(h, w[15:8]);
      end
      return h;
   endfunction

   task automatic predict_lookup();
      outcome_type o;
      key_type     k;
      logic [31:0] h;
      int          base, hit, free_way;
      o = '{ST_UNSUPPORTED, req_src_port, req_dst_port, req_protocol, 1'b0};
      h = '0;
      hit = -1;
      free_way = -1;
      if (req_ip_version == 4'd4) begin
         k = '{64'd0, {32'd0, req_src_addr_lo[31:0]}, 64'd0,
               {32'd0, req_dst_addr_lo[31:0]}, {17'd0, req_frag_id[15:0]}};
         h = mix32(h, req_src_addr_lo[31:0]);
         h = mix32(h, req_dst_addr_lo[31:0]);
         h = mix32(h, {16'd0, req_frag_id[15:0]});
      end else if (req_ip_version == 4'd6) begin
         k = '{req_src_addr_hi, req_src_addr_lo, req_dst_addr_hi, req_dst_addr_lo,
               {1'b1, req_frag_id}};
         h = mix128(h, {req_src_addr_hi, req_src_addr_lo});
         h = mix128(h, {req_dst_addr_hi, req_dst_addr_lo});
         h = mix32(h, req_frag_id);
      end
      if (req_ip_version == 4'd4 || req_ip_version == 4'd6) begin
         base = int'(h % TABLE_SETS) * TABLE_WAYS;
         for (int w = 0; w < TABLE_WAYS; w++) begin
            if (slot_valid[base+w]) begin
               if (hit < 0 && slot_key[base+w] == k) hit = base + w;
            end else if (free_way < 0) begin
               free_way = base + w;
            end
         end
         if (req_frag_offset == 13'd0) begin
            if (hit >= 0) o.status = ST_PRESENT;
            else if (free_way < 0) o.status = ST_FULL;
            else begin
               slot_valid[free_way] = 1'b1;
               slot_key[free_way] = k;
               slot_l4[free_way] = {req_src_port, req_dst_port, req_protocol};
               o.status = ST_RECORDED;
            end
         end else if (hit >= 0) begin
            {o.src_port, o.dst_port, o.protocol} = slot_l4[hit];
            o.status = ST_MATCHED;
            if (!req_more_fragments) begin
               slot_valid[hit] = 1'b0;
               o.released = 1'b1;
            end
         end else begin
            o.status = ST_UNMATCHED;
         end
      end
      outcome_q.push_back(o);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      failures++;
      $display("MISMATCH word %0d %s: got %0h want %0h", words_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         for (int i = 0; i < Entries; i++) slot_valid[i] = 1'b0;
         outcome_q.delete();
         failures = 0;
         words_seen = 0;
         matched_seen = 0;
         full_seen = 0;
      end else begin
         if (start && !busy) predict_lookup();
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               report("unexpected word", 32'(rsp_status), 32'd0);
            end else begin
               e = outcome_q.pop_front();
               if (rsp_status != e.status)
                  report("status", 32'(rsp_status), 32'(e.status));
               if (rsp_out_src_port != e.src_port)
                  report("src_port", 32'(rsp_out_src_port), 32'(e.src_port));
               if (rsp_out_dst_port != e.dst_port)
                  report("dst_port", 32'(rsp_out_dst_port), 32'(e.dst_port));
               if (rsp_out_protocol != e.protocol)
                  report("protocol", 32'(rsp_out_protocol), 32'(e.protocol));
               if (rsp_entry_released != e.released)
                  report("released", 32'(rsp_entry_released), 32'(e.released));
               if (e.status == ST_MATCHED) matched_seen++;
               if (e.status == ST_FULL) full_seen++;
            end
            words_seen++;
         end
      end
      pending = outcome_q.size();
   end

   initial begin
      failures = 0;
      pending = 0;
      words_seen = 0;
      matched_seen = 0;
      full_seen = 0;
   end
endmodule

FILE: bench/testbench.sv
// Testbench top: drives fragment descriptors into the L4 info table and gives the verdict.
module testbench;
   import ipfl4_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock, reset, start, busy;
   logic [3:0]  req_ip_version;
   logic [63:0] req_src_addr_hi, req_src_addr_lo, req_dst_addr_hi, req_dst_addr_lo;
   logic [31:0] req_frag_id;
   logic [12:0] req_frag_offset;
   logic        req_more_fragments;
   logic [15:0] req_src_port, req_dst_port;
   logic [7:0]  req_protocol;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_out_src_port, rsp_out_dst_port;
   logic [7:0]  rsp_out_protocol;
   logic        rsp_entry_released;
   int          failures, pending, words_seen, matched_seen, full_seen;
   int          sent;

   typedef struct {
      logic [3:0]  ver;
      logic [63:0] shi, slo, dhi, dlo;
      logic [31:0] id;
   } flow_type;

   flow_type flows[$];

   ip_fragment_l4_info_table_core dut (.*);
   ipfl4_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int v4_set(input flow_type f);
      logic [31:0] h;
      h = '0;
      for (int i = 0; i < 4; i++) h = sdbm_byte(h, f.slo[8*i +: 8]);
      for (int i = 0; i < 4; i++) h = sdbm_byte(h, f.dlo[8*i +: 8]);
      for (int i = 0; i < 2; i++) h = sdbm_byte(h, f.id[8*i +: 8]);
      for (int i = 0; i < 2; i++) h = sdbm_byte(h, 8'd0);
      return int'(h % DefaultSets);
   endfunction

   task automatic send(input flow_type f, input logic [12:0] offset, input logic more);
      req_ip_version <= f.ver;
      req_src_addr_hi <= f.shi;
      req_src_addr_lo <= f.slo;
      req_dst_addr_hi <= f.dhi;
      req_dst_addr_lo <= f.dlo;
      req_frag_id <= f.id;
      req_frag_offset <= offset;
      req_more_fragments <= more;
      req_src_port <= $urandom();
      req_dst_port <= $urandom();
      req_protocol <= $urandom();
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
   endtask

   task automatic gap();
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   function automatic flow_type new_flow(input logic [3:0] ver);
      flow_type f;
      f.ver = ver;
      f.shi = rand64();
      f.slo = rand64();
      f.dhi = rand64();
      f.dlo = rand64();
      f.id = $urandom();
      return f;
   endfunction

   initial begin
      flow_type f, g;
      flow_type fill[$];
      int       fill_set;
      int       burst;
      sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_ip_version = '0;
      req_src_addr_hi = '0;
      req_src_addr_lo = '0;
      req_dst_addr_hi = '0;
      req_dst_addr_lo = '0;
      req_frag_id = '0;
      req_frag_offset = '0;
      req_more_fragments = '0;
      req_src_port = '0;
      req_dst_port = '0;
      req_protocol = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every status, wide IPv4 fields
      f = '{4'd4, '1, '1, '1, '1, '1};
      send(f, 13'd0, 1'b1);
      f.shi = '0;
      f.slo = 64'h0000_0000_ffff_ffff;
      f.id = 32'h0000_ffff;
      send(f, 13'd0, 1'b0);
      send(f, 13'd8191, 1'b1);
      send(f, 13'd1, 1'b0);
      send(f, 13'd1, 1'b0);
      f = '{4'd6, '0, '0, '0, '0, '0};
      send(f, 13'd0, 1'b0);
      f.ver = 4'd4;
      send(f, 13'd0, 1'b1);
      send(f, 13'd5, 1'b0);
      f.ver = 4'd6;
      send(f, 13'd5, 1'b0);
      g = '{4'd6, '1, '1, '1, '1, '1};
      send(g, 13'd0, 1'b1);
      send(g, 13'd3, 1'b1);
      send(g, 13'd9, 1'b0);
      for (int v = 0; v < 16; v += 5) begin
         g.ver = v[3:0];
         if (v != 4) send(g, 13'd0, 1'b0);
      end
      g.ver = 4'd15;
      send(g, 13'd0, 1'b0);
      // fill one set past its ways with distinct keys, then release the recorded ones
      f = new_flow(4'd4);
      fill_set = v4_set(f);
      fill.push_back(f);
      while (fill.size() < DefaultWays + 1) begin
         g = new_flow(4'd4);
         if (v4_set(g) == fill_set && g.slo[31:0] != f.slo[31:0]) fill.push_back(g);
      end
      foreach (fill[i]) send(fill[i], 13'd0, 1'b1);
      foreach (fill[i]) send(fill[i], 13'd2, 1'b0);
      start <= 1'b0;
      wait (pending == 0);
      @(negedge clock);

      while (sent < 450) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            case ($urandom_range(0, 9))
               0: begin
                  f = new_flow(4'($urandom()));
                  send(f, 13'($urandom()), 1'($urandom()));
               end
               1, 2, 3: begin
                  f = new_flow($urandom_range(0, 1) ? 4'd4 : 4'd6);
                  if ($urandom_range(0, 3) == 0) begin
                     f.shi = '0;
                     f.dhi = '0;
                  end
                  send(f, 13'd0, 1'($urandom()));
                  if (flows.size() < 1500) flows.push_back(f);
               end
               default: begin
                  if (flows.size() == 0) begin
                     f = new_flow(4'd4);
                     send(f, 13'($urandom_range(1, 8191)), 1'b0);
                  end else begin
                     int idx;
                     idx = $urandom_range(0, flows.size() - 1);
                     f = flows[idx];
                     if ($urandom_range(0, 3) == 0) begin
                        send(f, 13'($urandom_range(1, 8191)), 1'b0);
                        flows.delete(idx);
                     end else begin
                        send(f, $urandom_range(0, 9) == 0 ? 13'd0 :
                             13'($urandom_range(1, 8191)), 1'b1);
                     end
                  end
               end
            endcase
         end
         gap();
         if (sent > 200 && sent < 215) begin
            wait (pending == 0);
            @(negedge clock);
         end
      end
      start <= 1'b0;
      wait (pending == 0);
      repeat (100) @(posedge clock);
      $display("Sent %0d descriptors, checked %0d results (%0d matched, %0d set full).",
               sent, words_seen, matched_seen, full_seen);
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
